// ----- sv/u8u4_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u4_pkg
// Shared constants, controller/datapath interface types and the unit
// formatting functions of the UTF-8 / UCS-4 transcoder.
// ----------------------------------------------------------------------------
package u8u4_pkg;

  // Port widths and default wide unit size
  localparam int DEF_WIDE_UNIT_BITS = 32;
  localparam int UNIT_W             = 32;
  localparam int BYTE_BITS          = 8;

  // Longest continuation run of one output sequence and its counter width
  localparam int MAX_CONT = 6;
  localparam int CNT_W    = 3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // take the input item into the collector
    logic advance;  // current output unit was taken
  } u8u4_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic done;     // the offered input item completes a code point
    logic last;     // the unit on the output is the final one
    logic dir;      // current direction register
  } u8u4_sts_t;

  // Logical right shift that yields zero for shifts of 32 or more
  function automatic logic [UNIT_W-1:0] shr_safe(input logic [UNIT_W-1:0] v, input int s);
    logic [UNIT_W-1:0] r;
    if (s >= UNIT_W) begin
      r = '0;
    end else begin
      r = v >> s;
    end
    return r;
  endfunction

  // Number of continuation units needed for a value at or above the top bit
  function automatic logic [CNT_W-1:0] unit_count(input logic [UNIT_W-1:0] v, input int bits);
    int                cb;
    logic [CNT_W-1:0]  cnt;
    cb  = bits - 2;
    cnt = CNT_W'(1);
    for (int k = 1; k < MAX_CONT; k++) begin
      if (shr_safe(v, cb + k * (cb - 1)) != '0) begin
        cnt = cnt + CNT_W'(1);
      end
    end
    return cnt;
  endfunction

  // Lead unit: ones prefix by count, then the top payload bits
  function automatic logic [UNIT_W-1:0] lead_unit(input logic [UNIT_W-1:0] v,
                                                  input logic [CNT_W-1:0]  cnt,
                                                  input int                bits);
    logic [UNIT_W-1:0] upper;
    logic [UNIT_W-1:0] wmask;
    int                cb;
    upper = UNIT_W'(1) << (bits - 1);
    wmask = upper | (upper - UNIT_W'(1));
    cb    = bits - 2;
    return (~((upper >> cnt) - UNIT_W'(1)) | shr_safe(v, int'(cnt) * cb)) & wmask;
  endfunction

  // Continuation unit: top bit set, payload slice selected by index
  function automatic logic [UNIT_W-1:0] cont_unit(input logic [UNIT_W-1:0] v,
                                                  input logic [CNT_W-1:0]  idx,
                                                  input int                bits);
    logic [UNIT_W-1:0] upper;
    logic [UNIT_W-1:0] wmask;
    logic [UNIT_W-1:0] cmask;
    int                cb;
    upper = UNIT_W'(1) << (bits - 1);
    wmask = upper | (upper - UNIT_W'(1));
    cb    = bits - 2;
    cmask = (UNIT_W'(1) << cb) - UNIT_W'(1);
    return (upper | (shr_safe(v, int'(idx) * cb) & cmask)) & wmask;
  endfunction

endpackage

// ----- sv/u8u4_ctrl.sv -----
// ----------------------------------------------------------------------------
// u8u4_ctrl
// Controller: takes input transactions until one completes a code point, then
// sequences the output transactions of that code point until the final unit is taken.
// ----------------------------------------------------------------------------
module u8u4_ctrl import u8u4_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  u8u4_sts_t sts_i,
  output u8u4_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q;
  logic state_d;

  // Handshake decode
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign cmd_o.load    = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.advance = out_valid_o && !out_stall_i;

  // Advance state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load && sts_i.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd_o.advance && sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/u8u4_dp.sv -----
// ----------------------------------------------------------------------------
// u8u4_dp
// Datapath: direction register, sequence collector and the output unit
// formatter with its emit position counter.
// ----------------------------------------------------------------------------
module u8u4_dp import u8u4_pkg::*; #(
  parameter int WIDE_UNIT_BITS = DEF_WIDE_UNIT_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [UNIT_W-1:0] src_unit_i,
  input  logic              end_of_string_i,
  input  u8u4_cmd_t         cmd_i,
  output u8u4_sts_t         sts_o,
  output logic [UNIT_W-1:0] dst_unit_o,
  output logic              run_last_o
);

  // Source side constants per direction
  localparam logic [UNIT_W-1:0] DEC_UPPER  = UNIT_W'(1) << (BYTE_BITS - 1);
  localparam logic [UNIT_W-1:0] DEC_SECOND = UNIT_W'(1) << (BYTE_BITS - 2);
  localparam logic [UNIT_W-1:0] ENC_UPPER  = UNIT_W'(1) << (WIDE_UNIT_BITS - 1);
  localparam logic [UNIT_W-1:0] ENC_SECOND = UNIT_W'(1) << (WIDE_UNIT_BITS - 2);
  localparam int                DEC_PM_SH  = BYTE_BITS - 3;
  localparam int                DEC_ACC_SH = BYTE_BITS - 2;
  localparam int                ENC_PM_SH  = WIDE_UNIT_BITS - 3;
  localparam int                ENC_ACC_SH = WIDE_UNIT_BITS - 2;

  logic              dir_q;
  logic              coll_q;
  logic              first_q;
  logic [UNIT_W-1:0] acc_q;
  logic [UNIT_W-1:0] pm_q;
  logic [CNT_W-1:0]  rem_q;

  logic [UNIT_W-1:0] s_upper;
  logic [UNIT_W-1:0] s_second;
  logic [UNIT_W-1:0] s_vmask;
  logic [UNIT_W-1:0] s_cmask;
  logic [UNIT_W-1:0] unit;
  logic [UNIT_W-1:0] pm_sh;
  logic [UNIT_W-1:0] acc_sh;
  logic [UNIT_W-1:0] acc_d;
  logic [UNIT_W-1:0] pm_d;
  logic              coll_d;
  logic              done;

  logic              one_unit;
  logic [CNT_W-1:0]  cnt;
  logic [UNIT_W-1:0] lead;
  logic [UNIT_W-1:0] cont;

  // Select source unit geometry
  assign s_upper  = dir_q ? ENC_UPPER : DEC_UPPER;
  assign s_second = dir_q ? ENC_SECOND : DEC_SECOND;
  assign s_vmask  = s_upper | (s_upper - UNIT_W'(1));
  assign s_cmask  = s_second - UNIT_W'(1);
  assign unit     = src_unit_i & s_vmask;

  // Shift the open sequence by one continuation
  assign pm_sh  = dir_q ? (pm_q << ENC_PM_SH) : (pm_q << DEC_PM_SH);
  assign acc_sh = dir_q ? ((acc_q & ~pm_q) << ENC_ACC_SH) : ((acc_q & ~pm_q) << DEC_ACC_SH);

  // Collect one source unit
  always_comb begin
    acc_d  = acc_q;
    pm_d   = pm_q;
    coll_d = coll_q;
    done   = 1'b0;
    if (!coll_q) begin
      acc_d  = unit;
      pm_d   = '0;
      coll_d = 1'b0;
      if ((unit & s_upper) != '0) begin
        acc_d  = unit & ~s_upper;
        pm_d   = s_second;
        coll_d = ((unit & s_second) != '0);
      end
      done = !coll_d;
    end else begin
      acc_d = acc_sh | (unit & s_cmask);
      pm_d  = pm_sh;
      if ((acc_d & pm_d) == '0) begin
        coll_d = 1'b0;
        done   = 1'b1;
      end
    end
    // Flush a partial sequence at end of string
    if (!done && coll_d && end_of_string_i) begin
      coll_d = 1'b0;
      done   = 1'b1;
    end
  end

  // Format the destination unit of the held code point
  assign one_unit = dir_q ? (acc_q < (UNIT_W'(1) << (BYTE_BITS - 1)))
                          : (acc_q < (UNIT_W'(1) << (WIDE_UNIT_BITS - 1)));
  assign cnt   = dir_q ? unit_count(acc_q, BYTE_BITS) : unit_count(acc_q, WIDE_UNIT_BITS);
  assign lead  = dir_q ? lead_unit(acc_q, cnt, BYTE_BITS)
                       : lead_unit(acc_q, cnt, WIDE_UNIT_BITS);
  assign cont  = dir_q ? cont_unit(acc_q, rem_q, BYTE_BITS)
                       : cont_unit(acc_q, rem_q, WIDE_UNIT_BITS);

  assign dst_unit_o = first_q ? (one_unit ? acc_q : lead) : cont;
  assign run_last_o = first_q ? one_unit : (rem_q == '0);

  assign sts_o.done = done;
  assign sts_o.last = run_last_o;
  assign sts_o.dir  = dir_q;

  // Hold state; a direction write abandons any open sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b0;
      coll_q  <= 1'b0;
      first_q <= 1'b0;
      acc_q   <= '0;
      pm_q    <= '0;
      rem_q   <= '0;
    end else if (cfg_we_i) begin
      dir_q  <= cfg_wdata_i;
      coll_q <= 1'b0;
      acc_q  <= '0;
      pm_q   <= '0;
    end else if (cmd_i.load) begin
      acc_q   <= acc_d;
      pm_q    <= pm_d;
      coll_q  <= coll_d;
      first_q <= 1'b1;
    end else if (cmd_i.advance) begin
      first_q <= 1'b0;
      rem_q   <= first_q ? (cnt - CNT_W'(1)) : (rem_q - CNT_W'(1));
    end
  end

endmodule

// ----- sv/utf8_ucs4_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf8_ucs4_transcoder
// Transcodes UTF-8 bytes to wide code units or wide code units to UTF-8
// bytes, direction chosen by a one-bit register.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------
//  input    | in        | in_valid_i / in_stall_o    | src_unit_i, end_of_string_i
//  output   | out       | out_valid_o / out_stall_i  | dst_unit_o, run_last_o
//  config   | in        | cfg_we_i                   | cfg_wdata_i (direction)
//
//  An input transaction that completes a code point holds the input
//  stalled while its n units (1..7) leave, one per cycle while the
//  output is not stalled.
//  A stalled output holds its unit and the emit counter.
//  Reset clears the direction (decode) and closes any open sequence.
//
module utf8_ucs4_transcoder import u8u4_pkg::*; #(
  parameter int WIDE_UNIT_BITS = DEF_WIDE_UNIT_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [UNIT_W-1:0] src_unit_i,
  input  logic              end_of_string_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [UNIT_W-1:0] dst_unit_o,
  output logic              run_last_o
);

  u8u4_cmd_t cmd;
  u8u4_sts_t sts;

  u8u4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  u8u4_dp #(
    .WIDE_UNIT_BITS (WIDE_UNIT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .src_unit_i      (src_unit_i),
    .end_of_string_i (end_of_string_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .dst_unit_o      (dst_unit_o),
    .run_last_o      (run_last_o)
  );

  // Final unit taken returns the block to accepting input
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && run_last_o |=> !out_valid_o)
    else $error("output still valid after final unit was taken");

  // An item that leaves a sequence open produces no output
  a_open_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !sts.done |=> !out_valid_o)
    else $error("output raised for an item that completes nothing");

  // Every unit but the final one carries the destination top bit
  a_multi_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |->
      (sts.dir ? dst_unit_o[BYTE_BITS-1] : dst_unit_o[WIDE_UNIT_BITS-1]))
    else $error("lead or continuation unit lacks its top bit");

  // Encoded bytes stay within the low byte
  a_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sts.dir |-> dst_unit_o[UNIT_W-1:BYTE_BITS] == '0)
    else $error("encoded unit exceeds one byte");

endmodule

// ----- bench/transcode_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// transcode_checker
// Watches the input, output and register ports of the transcoder, predicts
// the destination units of every input transaction and compares each output
// transaction against the oldest predicted unit.
// ----------------------------------------------------------------------------
module transcode_checker import u8u4_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [UNIT_W-1:0] src_unit_i,
  input  logic              end_of_string_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [UNIT_W-1:0] dst_unit_i,
  input  logic              run_last_i,
  output int                fail_count_o,
  output int                outstanding_o
);

  typedef struct packed {
    logic [UNIT_W-1:0] code;
    logic              last;
  } dst_item_t;

  dst_item_t         expected_units[$];
  int                mismatches;
  logic              dir_q;
  logic [UNIT_W-1:0] accum_q;
  logic [UNIT_W-1:0] pending_q;
  logic              open_q;

  // Right shift that clears the value once the shift covers the whole word
  function automatic logic [UNIT_W-1:0] drop_low(input logic [UNIT_W-1:0] v, input int s);
    return (s >= UNIT_W) ? '0 : (v >> s);
  endfunction

  // Append one predicted unit at the tail of the queue
  function automatic void queue_unit(input logic [UNIT_W-1:0] value, input logic is_last);
    dst_item_t item;
    item.code = value;
    item.last = is_last;
    expected_units.insert(expected_units.size(), item);
  endfunction

  // Split one code point into destination units of dbits bits each
  task automatic queue_code_point(input logic [UNIT_W-1:0] cp, input int dbits);
    logic [UNIT_W-1:0] upper;
    logic [UNIT_W-1:0] wmask;
    logic [UNIT_W-1:0] cmask;
    logic [UNIT_W-1:0] rest;
    int                cb;
    int                conts;
    upper = UNIT_W'(1) << (dbits - 1);
    wmask = upper | (upper - UNIT_W'(1));
    cb    = dbits - 2;
    cmask = (UNIT_W'(1) << cb) - UNIT_W'(1);
    if (cp < upper) begin
      queue_unit(cp, 1'b1);
    end else begin
      conts = 0;
      rest  = cp >> cb;
      while (rest != '0) begin
        rest  = rest >> (cb - 1);
        conts = conts + 1;
      end
      // lead: ones prefix by run length, then whatever payload still fits
      queue_unit((~((upper >> conts) - UNIT_W'(1)) | drop_low(cp, conts * cb)) & wmask,
                 1'b0);
      for (int k = conts - 1; k >= 0; k--) begin
        queue_unit((upper | (drop_low(cp, k * cb) & cmask)) & wmask, k == 0);
      end
    end
  endtask

  // Advance the sequence collector by one source unit
  task automatic transcode_step(input logic [UNIT_W-1:0] raw, input logic eos);
    int                sbits;
    int                dbits;
    logic [UNIT_W-1:0] s_upper;
    logic [UNIT_W-1:0] s_second;
    logic [UNIT_W-1:0] unit;
    logic              finished;
    sbits    = dir_q ? DEF_WIDE_UNIT_BITS : BYTE_BITS;
    dbits    = dir_q ? BYTE_BITS : DEF_WIDE_UNIT_BITS;
    s_upper  = UNIT_W'(1) << (sbits - 1);
    s_second = UNIT_W'(1) << (sbits - 2);
    unit     = raw & (s_upper | (s_upper - UNIT_W'(1)));
    finished = 1'b0;
    if (!open_q) begin
      accum_q   = unit;
      pending_q = '0;
      if ((accum_q & s_upper) != '0) begin
        accum_q   = accum_q & ~s_upper;
        pending_q = s_second;
        if ((accum_q & pending_q) != '0) begin
          open_q = 1'b1;
        end
      end
      if (!open_q) begin
        finished = 1'b1;
      end
    end else begin
      // continuation: no check of its marker bits, accumulator wraps
      accum_q   = accum_q & ~pending_q;
      pending_q = pending_q << (sbits - 3);
      accum_q   = (accum_q << (sbits - 2)) | (unit & (s_second - UNIT_W'(1)));
      if ((accum_q & pending_q) == '0) begin
        open_q   = 1'b0;
        finished = 1'b1;
      end
    end
    // end of string flushes an open sequence as it stands
    if (!finished && open_q && eos) begin
      open_q   = 1'b0;
      finished = 1'b1;
    end
    if (finished) begin
      queue_code_point(accum_q, dbits);
      accum_q   = '0;
      pending_q = '0;
    end
  endtask

  // Track register writes, predict on input transactions, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    dst_item_t want;
    if (!rst_ni) begin
      dir_q      = 1'b0;
      accum_q    = '0;
      pending_q  = '0;
      open_q     = 1'b0;
      mismatches = 0;
      expected_units.delete();
    end else begin
      if (cfg_we_i) begin
        dir_q     = cfg_wdata_i;
        accum_q   = '0;
        pending_q = '0;
        open_q    = 1'b0;
      end
      if (in_valid_i && !in_stall_i) begin
        transcode_step(src_unit_i, end_of_string_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_units.size() == 0) begin
          $error("unexpected output transaction: dst_unit %h run_last %b",
                 dst_unit_i, run_last_i);
          mismatches++;
        end else begin
          want = expected_units.pop_front();
          if (dst_unit_i !== want.code) begin
            $error("dst_unit: expected %h, actual %h", want.code, dst_unit_i);
            mismatches++;
          end
          if (run_last_i !== want.last) begin
            $error("run_last: expected %b, actual %b", want.last, run_last_i);
            mismatches++;
          end
        end
      end
    end
    fail_count_o  <= mismatches;
    outstanding_o <= expected_units.size();
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives UTF-8 bytes and wide code units through the transcoder in both
// directions, with random gaps on the input and random stalls on the output;
// a checker beside the block predicts and compares every destination unit.
// ----------------------------------------------------------------------------
module testbench import u8u4_pkg::*;;

  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 20;
  localparam int PHASE_ITEMS = 38;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [UNIT_W-1:0] src_unit_i;
  logic              end_of_string_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [UNIT_W-1:0] dst_unit_o;
  logic              run_last_o;

  int   fail_count;
  int   outstanding;
  int   items_sent;
  int   idle_cycles = 0;
  int   stall_left  = 0;
  logic gaps_on;
  logic stalls_on;

  always #5 clk_i = ~clk_i;

  utf8_ucs4_transcoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .src_unit_i      (src_unit_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dst_unit_o      (dst_unit_o),
    .run_last_o      (run_last_o)
  );

  transcode_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .src_unit_i      (src_unit_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dst_unit_i      (dst_unit_o),
    .run_last_i      (run_last_o),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  // Stall the output in random bursts: mostly short, a few long
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stalls_on || r < 60) begin
      out_stall_i <= 1'b0;
      stall_left  <= $urandom_range(0, 6);
    end else if (r < 95) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(8, 30);
    end
  end

  // End the run when no transaction has moved for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 25);
  endfunction

  // Offer one source unit and hold it until the input transaction completes
  task automatic push_unit(input logic [UNIT_W-1:0] unit, input logic eos);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    src_unit_i      <= unit;
    end_of_string_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted unit has left
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic set_direction(input logic dir);
    wait_drained();
    repeat (12) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dir;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One UTF-8 sequence with random content, or a noise byte
  task automatic decode_run();
    int         kind;
    int         conts;
    logic [7:0] lead;
    logic [7:0] piece;
    logic       cut;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      push_unit($urandom(), $urandom_range(0, 7) == 0);
    end else begin
      conts = $urandom_range(0, 6);
      if (conts == 0) begin
        lead = ($urandom_range(0, 3) == 0) ? 8'h80 | 8'($urandom_range(0, 63))
                                           : 8'($urandom_range(0, 127));
      end else if (conts == 6) begin
        lead = 8'hFE | 8'($urandom_range(0, 1));
      end else begin
        lead = (8'hFF << (7 - conts)) | (8'($urandom()) & ((8'h1 << (6 - conts)) - 8'h1));
      end
      // truncate some sequences and flush them with end of string
      cut = (conts != 0) && ($urandom_range(0, 5) == 0);
      if (cut) begin
        conts = $urandom_range(0, conts - 1);
      end
      for (int i = 0; i <= conts; i++) begin
        if (i == 0) begin
          piece = lead;
        end else if ($urandom_range(0, 4) == 0) begin
          piece = 8'($urandom());
        end else begin
          piece = 8'h80 | 8'($urandom_range(0, 63));
        end
        push_unit(($urandom() & 32'hFFFF_FF00) | UNIT_W'(piece),
                  (i == conts) && (cut || $urandom_range(0, 3) == 0));
      end
    end
  endtask

  // One wide code unit, or a two-unit wide sequence, with random magnitude
  task automatic encode_run();
    int                kind;
    logic [UNIT_W-1:0] lead;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      push_unit($urandom() >> $urandom_range(1, 31), $urandom_range(0, 3) == 0);
    end else if (kind < 70) begin
      push_unit(32'h8000_0000 | ($urandom() & 32'h3FFF_FFFF), $urandom_range(0, 3) == 0);
    end else begin
      lead = 32'hC000_0000 | ($urandom() & 32'h3FFF_FFFF);
      if (kind < 76) begin
        push_unit(lead, 1'b1);
      end else begin
        push_unit(lead, 1'b0);
        push_unit($urandom(), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    int target;
    logic dir;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 1'b0;
    in_valid_i      <= 1'b0;
    src_unit_i      <= '0;
    end_of_string_i <= 1'b0;
    gaps_on         <= 1'b1;
    stalls_on       <= 1'b1;
    items_sent      = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed decode: ASCII extremes, stray continuation byte, two-byte, longest run
    // that wraps the accumulator, truncated run flushed by end of string
    set_direction(1'b0);
    push_unit(32'h00, 1'b0);
    push_unit(32'h7F, 1'b0);
    push_unit(32'h80, 1'b0);
    push_unit(32'hC3, 1'b0);
    push_unit(32'hA9, 1'b0);
    push_unit(32'hFE, 1'b0);
    for (int i = 0; i < 6; i++) begin
      push_unit(32'hBF, i == 5);
    end
    push_unit(32'hE2, 1'b0);
    push_unit(32'h82, 1'b1);
    // leave a sequence open across a direction change
    push_unit(32'hF0, 1'b0);
    set_direction(1'b1);

    // Directed encode: single bytes, seven-byte worst case, top-bit units,
    // two-unit wide sequence, flush and an abandoned open sequence
    push_unit(32'h0000_0000, 1'b0);
    push_unit(32'h0000_007F, 1'b0);
    push_unit(32'h0000_0080, 1'b0);
    push_unit(32'h7FFF_FFFF, 1'b0);
    push_unit(32'h8000_0000, 1'b0);
    push_unit(32'hFFFF_FFFF, 1'b0);
    push_unit(32'hFFFF_FFFF, 1'b0);
    push_unit(32'hC000_0001, 1'b1);
    push_unit(32'hC000_0000, 1'b0);

    // Random phases, varying direction and idling pattern
    for (int p = 0; p < 6; p++) begin
      dir = (p == 0 || p == 2 || p == 5);
      set_direction(dir);
      gaps_on   <= (p % 3 != 2);
      stalls_on <= (p % 3 != 1);
      target    = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 19) == 0) begin
          wait_drained();
        end
        if (dir) begin
          encode_run();
        end else begin
          decode_run();
        end
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
